[sv/substring_search_stream_defines.svh]
// Assertion macros for the substring search block.
// Used by the top level only; depends on nothing else.
`ifndef SUBSTRING_SEARCH_STREAM_DEFINES_SVH
`define SUBSTRING_SEARCH_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sss_pkg.sv]
// Shared types, constants and helper functions for the substring search block.
// Used by the interfaces, the window compare and the top level.
package sss_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 6;
    localparam int POS_BITS    = 32;
    localparam int CHAR_W      = 8;
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 6;
    localparam int PAT_REGS    = 4;

    // Register slots on the configuration port, 8 bytes apart.
    typedef enum logic [2:0] {
        CFG_PAT0 = 3'd0,
        CFG_PAT1 = 3'd1,
        CFG_PAT2 = 3'd2,
        CFG_PAT3 = 3'd3,
        CFG_LEN  = 3'd4,
        CFG_BACK = 3'd5,
        CFG_CASE = 3'd6
    } t_cfg_idx;

    typedef logic [CHAR_W-1:0] t_char;

    // Pattern as seen by the window compare: expected byte per window slot,
    // already aligned and folded, plus the slots that take part.
    typedef struct packed {
        logic [PATTERN_MAX-1:0][CHAR_W-1:0] exp_bytes;
        logic [PATTERN_MAX-1:0]             use_mask;
        logic                               caseless;
    } t_match_cfg;

    function automatic t_char f_fold(input t_char c, input logic caseless);
        t_char r;
        r = c;
        if (caseless && (c >= 8'h61) && (c <= 8'h7A)) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

[sv/sss_if.sv]
// Valid/ready channel interfaces for the substring search block.
// Depends on sss_pkg for the character and count widths.
interface sss_text_if import sss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sss_result_if import sss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                found;
    logic [POS_BITS-1:0] chars_scanned;

    modport source (output valid, output found, output chars_scanned, input ready);
    modport sink   (input valid, input found, input chars_scanned, output ready);
endinterface

[sv/sss_window.sv]
// Sliding window of the most recent characters and its parallel pattern compare.
// Depends on sss_pkg for t_match_cfg and f_fold.
module sss_window import sss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_shift,
    input  t_char      i_char,
    input  t_match_cfg i_cfg,
    output logic       o_hit
);

    t_char [PATTERN_MAX-1:0] r_win;
    t_char [PATTERN_MAX-1:0] n_win;
    logic  [PATTERN_MAX-1:0] w_ok;

    // The compare looks at the window as it will be once the new character is in.
    always_comb begin
        n_win[0] = i_char;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            n_win[k] = r_win[k-1];
        end
        for (int k = 0; k < PATTERN_MAX; k++) begin
            w_ok[k] = !i_cfg.use_mask[k]
                   || (f_fold(n_win[k], i_cfg.caseless) == i_cfg.exp_bytes[k]);
        end
    end

    assign o_hit = &w_ok;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win <= n_win;
        end
    end

endmodule

[sv/substring_search_stream.sv]
// Streaming substring search: top level with configuration registers and item flow.
// Depends on sss_pkg, sss_if.sv, sss_window and substring_search_stream_defines.svh.
//
// The block looks for the first occurrence of a pattern of 1 to 32 bytes in a
// stream of text characters, one character per input item. Each item is taken
// into an input register; from there the character is shifted into a 32-byte
// window and the newest pattern-length characters are compared with the pattern
// in parallel, the result going to an output register. The block takes one item
// every cycle unless a result held at the output stalls it. A result is written
// to the output register when the item that causes it leaves the input register.
// The only stall comes from a result held at the output: while it is not taken,
// the item in the input register waits, whether or not it has a result of its
// own, and no new item is accepted. A result (found=1 and the count
// of characters up to the match end) is emitted on the first match; later items
// up to and including the one marked end_of_text are then dropped without a
// result. Without a match, the item marked end_of_text produces found=0 and the
// full count. The next item after end_of_text starts a new search. The count
// saturates at 2^32-1. In backward mode the first character received is matched
// against the last pattern byte; in caseless mode ASCII letters are folded to
// upper case on both sides. A pattern length of 0 acts as 1 and lengths above
// 32 act as 32. Configuration sits on an APB-style port with 64-bit data,
// register n at byte address 8*n; it is to be written while no search is
// pending a result. There is no clearing pass after reset.
`include "substring_search_stream_defines.svh"

module substring_search_stream import sss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sss_text_if.sink          i_text_ch,
    sss_result_if.source      o_result_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PAT_REGS-1:0][APB_DW-1:0] r_pat;
    logic [LEN_W-1:0]                r_len;
    logic                            r_back;
    logic                            r_case;
    t_cfg_idx                        w_idx;
    logic                            w_cfg_wr;

    assign pready   = 1'b1;
    assign w_idx    = t_cfg_idx'(paddr[APB_AW-1:3]);
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_len  <= LEN_W'(1);
            r_back <= 1'b0;
            r_case <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                CFG_PAT0: r_pat[0] <= pwdata;
                CFG_PAT1: r_pat[1] <= pwdata;
                CFG_PAT2: r_pat[2] <= pwdata;
                CFG_PAT3: r_pat[3] <= pwdata;
                CFG_LEN:  r_len    <= pwdata[LEN_W-1:0];
                CFG_BACK: r_back   <= pwdata[0];
                CFG_CASE: r_case   <= pwdata[0];
                default: begin
                    // Addresses past the register list are ignored.
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            CFG_PAT0: prdata = r_pat[0];
            CFG_PAT1: prdata = r_pat[1];
            CFG_PAT2: prdata = r_pat[2];
            CFG_PAT3: prdata = r_pat[3];
            CFG_LEN:  prdata = APB_DW'(r_len);
            CFG_BACK: prdata = APB_DW'(r_back);
            CFG_CASE: prdata = APB_DW'(r_case);
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective length and the aligned, folded pattern. The pattern view is
    // registered so the window compare sees only a byte compare per slot.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]              w_eff_len;
    t_char [PATTERN_MAX-1:0]       w_pat_bytes;
    t_match_cfg                    n_mcfg;
    t_match_cfg                    r_mcfg;

    always_comb begin
        if (r_len == '0) begin
            w_eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(PATTERN_MAX)) begin
            w_eff_len = LEN_W'(PATTERN_MAX);
        end else begin
            w_eff_len = r_len;
        end
    end

    assign w_pat_bytes = r_pat;

    always_comb begin
        logic [LEN_W-1:0] pi;
        n_mcfg.caseless = r_case;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            // Forward mode: the newest character meets the last pattern byte.
            if (r_back) begin
                pi = LEN_W'(k);
            end else begin
                pi = w_eff_len - LEN_W'(1) - LEN_W'(k);
            end
            n_mcfg.exp_bytes[k] = f_fold(w_pat_bytes[pi[IDX_W-1:0]], r_case);
            n_mcfg.use_mask[k]  = (LEN_W'(k) < w_eff_len);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcfg <= n_mcfg;
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic  r_in_valid;
    t_char r_in_char;
    logic  r_in_eot;
    logic  w_in_acc;
    logic  w_proc;

    // An item is processed when the output register is free or being emptied.
    assign w_proc           = r_in_valid && (!o_result_ch.valid || o_result_ch.ready);
    assign i_text_ch.ready  = !r_in_valid || w_proc;
    assign w_in_acc         = i_text_ch.valid && i_text_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text_ch.ready) begin
            r_in_valid <= i_text_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_char <= i_text_ch.text_byte;
            r_in_eot  <= i_text_ch.end_of_text;
        end
    end

    // ------------------------------------------------------------------
    // Search state and window compare
    // ------------------------------------------------------------------
    logic [POS_BITS-1:0] r_count;
    logic [POS_BITS-1:0] w_count_next;
    logic                r_finished;
    logic                w_shift;
    logic                w_win_hit;
    logic                w_hit;
    logic                w_emit;

    assign w_shift      = w_proc && !r_finished;
    assign w_count_next = (&r_count) ? r_count : r_count + POS_BITS'(1);
    // No match until the window holds a full pattern's worth of this search.
    assign w_hit        = w_win_hit && (w_count_next >= POS_BITS'(w_eff_len));
    assign w_emit       = w_shift && (w_hit || r_in_eot);

    sss_window u_window (
        .i_clk   (i_clk),
        .i_shift (w_shift),
        .i_char  (r_in_char),
        .i_cfg   (r_mcfg),
        .o_hit   (w_win_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_finished <= 1'b0;
        end else if (w_proc) begin
            if (r_in_eot) begin
                // End of text always closes the search, matched or not.
                r_count    <= '0;
                r_finished <= 1'b0;
            end else if (!r_finished) begin
                r_count    <= w_count_next;
                r_finished <= w_hit;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                r_out_valid;
    logic                r_out_found;
    logic [POS_BITS-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_found <= w_hit;
            r_out_count <= w_count_next;
        end
    end

    assign o_result_ch.valid         = r_out_valid;
    assign o_result_ch.found         = r_out_found;
    assign o_result_ch.chars_scanned = r_out_count;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SSS_ASSERT_NEXT(a_hit_sets_finished, i_clk, i_rst_n,
        w_shift && w_hit && !r_in_eot, r_finished,
        "match before end of text did not start the ignored run")
    `SSS_ASSERT_NEXT(a_eot_restarts, i_clk, i_rst_n,
        w_proc && r_in_eot, (r_count == '0) && !r_finished,
        "end of text did not restart the search")
    `SSS_ASSERT_NEXT(a_ignored_no_result, i_clk, i_rst_n,
        w_proc && r_finished,
        r_out_valid == $past(r_out_valid && !o_result_ch.ready),
        "an ignored item produced a result")

endmodule
